[rtl/hsw_pkg.sv]
// hsw_pkg: shared constants, register indexes and control types for the
// hillshade window block. Used by the interfaces, the cells and the top level.
package hsw_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS       = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int P_BITS          = 32;
  localparam int SUN_BITS        = 32;
  localparam int SCALE_BITS      = 24;
  localparam int NINV_BITS       = 17;
  localparam int SHADE_BITS      = 16;
  localparam int MASK_BITS       = 9;

  // Datapath widths
  localparam int PROD_BITS = 2 * P_BITS;              // full 32x32 product
  localparam int NUM_BITS  = PROD_BITS - FRAC_BITS + 2; // numerator, signed
  localparam int NRM_BITS  = NUM_BITS + NINV_BITS;    // |num| * norm
  localparam int RAD_BITS  = 2 * P_BITS;              // radicand
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 3;           // square-root remainder
  localparam int QUO_BITS  = 16 + (FRAC_BITS - 15) + 1; // quotient bits kept
  localparam int HI_BITS   = NRM_BITS - QUO_BITS;
  localparam int SQ_CELLS  = RAD_BITS / 2;

  localparam logic [NINV_BITS-1:0] ONE_FX      = NINV_BITS'(1) << FRAC_BITS;
  localparam logic [RAD_BITS-1:0]  RAD_BIAS    = RAD_BITS'(1) << (2 * FRAC_BITS);
  localparam logic [PROD_BITS-1:0] TRUNC_ADJ   = PROD_BITS'((1 << FRAC_BITS) - 1);
  localparam logic [P_BITS-1:0]    P_MAX       = {1'b0, {(P_BITS-1){1'b1}}};
  localparam logic [P_BITS-1:0]    P_MIN       = {1'b1, {(P_BITS-1){1'b0}}};
  localparam logic [SHADE_BITS-1:0] SHADE_MAX  = {1'b0, {(SHADE_BITS-1){1'b1}}};
  localparam logic [SHADE_BITS-1:0] SHADE_MIN  = {1'b1, {(SHADE_BITS-1){1'b0}}};

  // Configuration port
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUN_P        = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUN_Q        = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRAD_SCALE   = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUN_NORM_INV = 8'd3;

  localparam logic [SCALE_BITS-1:0] GRAD_SCALE_RST = 24'd21845;
  localparam logic [NINV_BITS-1:0]  NINV_RST       = 17'd65536;

  // Per-item control that rides along the cell chains
  typedef struct packed {
    logic valid;
    logic is_null;
    logic neg;
    logic ovf;
  } ctl_t;

endpackage

[rtl/hsw_ifs.sv]
// Handshake interfaces for the hillshade window block: window in, config
// write, shade out. Depends on hsw_pkg.
interface hsw_win_if import hsw_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] top_left;
  logic signed [SAMPLE_BITS-1:0] top_mid;
  logic signed [SAMPLE_BITS-1:0] top_right;
  logic signed [SAMPLE_BITS-1:0] mid_left;
  logic signed [SAMPLE_BITS-1:0] center;
  logic signed [SAMPLE_BITS-1:0] mid_right;
  logic signed [SAMPLE_BITS-1:0] bottom_left;
  logic signed [SAMPLE_BITS-1:0] bottom_mid;
  logic signed [SAMPLE_BITS-1:0] bottom_right;
  logic [MASK_BITS-1:0]          special_mask;

  modport source (output valid, top_left, top_mid, top_right, mid_left, center,
                  mid_right, bottom_left, bottom_mid, bottom_right, special_mask,
                  input ready);
  modport sink (input valid, top_left, top_mid, top_right, mid_left, center,
                mid_right, bottom_left, bottom_mid, bottom_right, special_mask,
                output ready);
endinterface

interface hsw_cfg_if import hsw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface hsw_shade_if import hsw_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [SHADE_BITS-1:0] shade;
  logic                         is_null;

  modport source (output valid, shade, is_null, input ready);
  modport sink (input valid, shade, is_null, output ready);
endinterface

[rtl/hillshade_window_3x3.sv]
// hillshade_window_3x3: shaded-relief reflectance of a 3x3 window, pipelined.
// Depends on hsw_pkg, hsw_ifs, hsw_sqrt_cell and hsw_div_cell.
//
//   port    dir   transaction                        handshake
//   win     in    nine samples + special mask        valid/ready
//   cfg     in    register index + write data        valid/ready (always ready)
//   res     out   shade Q1.15 + null flag            valid/ready
//
// One window enters per cycle while win.ready is high; it passes the stage registers,
// the 32 square-root cells, the division setup, the 18 division cells and the output.
// Reset is synchronous and clears valid bits and the registers to defaults.
// A stalled result parks in a skid register; the chain stops only when that
// register is full, and win.ready is low only then.
module hillshade_window_3x3 import hsw_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  hsw_win_if.sink      win,
  hsw_cfg_if.sink      cfg,
  hsw_shade_if.source  res
);

  localparam int GRAD_BITS = SAMPLE_BITS + 3;
  localparam int PX_BITS   = GRAD_BITS + SCALE_BITS + 1;
  localparam int SHIFT     = FRAC_BITS - 15;

  // configuration registers
  logic signed [SUN_BITS-1:0] sun_p;
  logic signed [SUN_BITS-1:0] sun_q;
  logic [SCALE_BITS-1:0]      grad_scale;
  logic [NINV_BITS-1:0]       sun_norm_inv;
  logic [NINV_BITS-1:0]       ninv_c;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sun_p        <= '0;
      sun_q        <= '0;
      grad_scale   <= GRAD_SCALE_RST;
      sun_norm_inv <= NINV_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SUN_P:        sun_p        <= cfg.data;
        REG_SUN_Q:        sun_q        <= cfg.data;
        REG_GRAD_SCALE:   grad_scale   <= cfg.data[SCALE_BITS-1:0];
        REG_SUN_NORM_INV: sun_norm_inv <= cfg.data[NINV_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign ninv_c = (sun_norm_inv > ONE_FX) ? ONE_FX : sun_norm_inv;

  // pipeline enable and skid/output registers
  logic                  en;
  logic                  skid_valid;
  logic signed [SHADE_BITS-1:0] skid_shade;
  logic                  skid_null;
  logic                  out_valid;
  logic signed [SHADE_BITS-1:0] out_shade;
  logic                  out_null;

  assign en        = ~skid_valid;
  assign win.ready = en;

  // stage 1: column and row differences
  logic                        v1, n1;
  logic signed [GRAD_BITS-1:0] gx1, gy1;
  logic signed [GRAD_BITS-1:0] e0, e1, e2, e3, e5, e6, e7, e8;

  always_comb begin
    e0 = GRAD_BITS'(win.top_left);
    e1 = GRAD_BITS'(win.top_mid);
    e2 = GRAD_BITS'(win.top_right);
    e3 = GRAD_BITS'(win.mid_left);
    e5 = GRAD_BITS'(win.mid_right);
    e6 = GRAD_BITS'(win.bottom_left);
    e7 = GRAD_BITS'(win.bottom_mid);
    e8 = GRAD_BITS'(win.bottom_right);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= win.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1  <= |win.special_mask;
      gx1 <= (e0 + e3 + e6) - (e2 + e5 + e8);
      gy1 <= (e0 + e1 + e2) - (e6 + e7 + e8);
    end
  end

  // stage 2: scale gradients, saturate to 32 bits
  logic                      v2, n2;
  logic signed [P_BITS-1:0]  p2, q2;
  logic signed [PX_BITS-1:0] px, qx;
  logic [P_BITS-1:0]         p_sat, q_sat;

  always_comb begin
    px = gx1 * $signed({1'b0, grad_scale});
    qx = gy1 * $signed({1'b0, grad_scale});
    if ((&px[PX_BITS-1:P_BITS-1]) || !(|px[PX_BITS-1:P_BITS-1])) begin
      p_sat = px[P_BITS-1:0];
    end else begin
      p_sat = px[PX_BITS-1] ? P_MIN : P_MAX;
    end
    if ((&qx[PX_BITS-1:P_BITS-1]) || !(|qx[PX_BITS-1:P_BITS-1])) begin
      q_sat = qx[P_BITS-1:0];
    end else begin
      q_sat = qx[PX_BITS-1] ? P_MIN : P_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2 <= n1;
      p2 <= p_sat;
      q2 <= q_sat;
    end
  end

  // stage 3: sun products and squares
  logic                        v3, n3;
  logic signed [PROD_BITS-1:0] mp3, mq3, sp3, sq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3  <= n2;
      mp3 <= sun_p * p2;
      mq3 <= sun_q * q2;
      sp3 <= p2 * p2;
      sq3 <= q2 * q2;
    end
  end

  // stage 4: numerator (truncating toward zero) and radicand
  logic                        v4, n4, neg4;
  logic [NUM_BITS-1:0]         mag4;
  logic [RAD_BITS-1:0]         rad4;
  logic signed [PROD_BITS-1:0] mp_adj, mq_adj, mp_t, mq_t;
  logic [NUM_BITS-1:0]         num;

  always_comb begin
    mp_adj = mp3 + (mp3[PROD_BITS-1] ? $signed(TRUNC_ADJ) : '0);
    mq_adj = mq3 + (mq3[PROD_BITS-1] ? $signed(TRUNC_ADJ) : '0);
    mp_t   = mp_adj >>> FRAC_BITS;
    mq_t   = mq_adj >>> FRAC_BITS;
    num    = NUM_BITS'(ONE_FX) + mp_t[NUM_BITS-1:0] + mq_t[NUM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n4   <= n3;
      neg4 <= num[NUM_BITS-1];
      mag4 <= num[NUM_BITS-1] ? (~num + 1'b1) : num;
      rad4 <= RAD_BIAS + sp3 + sq3;
    end
  end

  // stage 5: apply the sun normalization to the magnitude
  ctl_t                 ctl5;
  logic [NRM_BITS-1:0]  nrm5;
  logic [RAD_BITS-1:0]  rad5;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5 <= '0;
    end else if (en) begin
      ctl5.valid   <= v4;
      ctl5.is_null <= n4;
      ctl5.neg     <= neg4;
      ctl5.ovf     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm5 <= mag4 * ninv_c;
      rad5 <= rad4;
    end
  end

  // square-root chain
  ctl_t                 sq_ctl  [SQ_CELLS+1];
  logic [RAD_BITS-1:0]  sq_rad  [SQ_CELLS+1];
  logic [REM_BITS-1:0]  sq_rem  [SQ_CELLS+1];
  logic [ROOT_BITS-1:0] sq_root [SQ_CELLS+1];
  logic [NRM_BITS-1:0]  sq_nrm  [SQ_CELLS+1];

  assign sq_ctl[0]  = ctl5;
  assign sq_rad[0]  = rad5;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_nrm[0]  = nrm5;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    hsw_sqrt_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctl_i  (sq_ctl[k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .nrm_i  (sq_nrm[k]),
      .ctl_o  (sq_ctl[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .nrm_o  (sq_nrm[k+1])
    );
  end

  // division setup: quotient at or above 2^QUO_BITS saturates
  ctl_t                 dv_ctl [QUO_BITS+1];
  logic [ROOT_BITS-1:0] dv_den [QUO_BITS+1];
  logic [ROOT_BITS-1:0] dv_rem [QUO_BITS+1];
  logic [QUO_BITS-1:0]  dv_lo  [QUO_BITS+1];
  logic [QUO_BITS-1:0]  dv_quo [QUO_BITS+1];
  logic [HI_BITS-1:0]   nrm_hi;
  logic                 ovf;

  always_comb begin
    nrm_hi = sq_nrm[SQ_CELLS][NRM_BITS-1:QUO_BITS];
    ovf    = nrm_hi >= HI_BITS'(sq_root[SQ_CELLS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0] <= '0;
    end else if (en) begin
      dv_ctl[0].valid   <= sq_ctl[SQ_CELLS].valid;
      dv_ctl[0].is_null <= sq_ctl[SQ_CELLS].is_null;
      dv_ctl[0].neg     <= sq_ctl[SQ_CELLS].neg;
      dv_ctl[0].ovf     <= ovf;
    end
  end

  // without overflow the high part is below the root, so it fits its width
  always_ff @(posedge clk) begin
    if (en) begin
      dv_den[0] <= sq_root[SQ_CELLS];
      dv_rem[0] <= ovf ? '0 : nrm_hi[ROOT_BITS-1:0];
      dv_lo[0]  <= sq_nrm[SQ_CELLS][QUO_BITS-1:0];
      dv_quo[0] <= '0;
    end
  end

  // division chain
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    hsw_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .ctl_i (dv_ctl[k]),
      .den_i (dv_den[k]),
      .rem_i (dv_rem[k]),
      .lo_i  (dv_lo[k]),
      .quo_i (dv_quo[k]),
      .ctl_o (dv_ctl[k+1]),
      .den_o (dv_den[k+1]),
      .rem_o (dv_rem[k+1]),
      .lo_o  (dv_lo[k+1]),
      .quo_o (dv_quo[k+1])
    );
  end

  // Q1.15 scaling, sign and saturation
  ctl_t                         fin;
  logic [QUO_BITS-1:0]          mag_q;
  logic [SHADE_BITS-1:0]        shade_val;

  always_comb begin
    fin   = dv_ctl[QUO_BITS];
    mag_q = dv_quo[QUO_BITS] >> SHIFT;
    if (fin.is_null) begin
      shade_val = '0;
    end else if (fin.neg) begin
      if (fin.ovf || mag_q > QUO_BITS'(SHADE_MIN)) begin
        shade_val = SHADE_MIN;
      end else begin
        shade_val = SHADE_BITS'(~mag_q + 1'b1);
      end
    end else begin
      if (fin.ovf || mag_q > QUO_BITS'(SHADE_MAX)) begin
        shade_val = SHADE_MAX;
      end else begin
        shade_val = mag_q[SHADE_BITS-1:0];
      end
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= fin.valid;
      end
    end else if (fin.valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_shade <= skid_shade;
        out_null  <= skid_null;
      end else begin
        out_shade <= shade_val;
        out_null  <= fin.is_null;
      end
    end else if (fin.valid && en) begin
      skid_shade <= shade_val;
      skid_null  <= fin.is_null;
    end
  end

  assign res.valid   = out_valid;
  assign res.shade   = out_shade;
  assign res.is_null = out_null;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_null) |-> (out_shade == '0))
    else $error("null result carries a nonzero shade");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && res.ready) |=> !skid_valid)
    else $error("skid register did not drain after output was taken");

endmodule

[rtl/hsw_sqrt_cell.sv]
// hsw_sqrt_cell: one digit step of the integer square root, registered.
// Also carries the normalized numerator and control along. Depends on hsw_pkg.
module hsw_sqrt_cell import hsw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctl_t                 ctl_i,
  input  logic [RAD_BITS-1:0]  rad_i,
  input  logic [REM_BITS-1:0]  rem_i,
  input  logic [ROOT_BITS-1:0] root_i,
  input  logic [NRM_BITS-1:0]  nrm_i,
  output ctl_t                 ctl_o,
  output logic [RAD_BITS-1:0]  rad_o,
  output logic [REM_BITS-1:0]  rem_o,
  output logic [ROOT_BITS-1:0] root_o,
  output logic [NRM_BITS-1:0]  nrm_o
);

  logic [REM_BITS-1:0] rem_sh;
  logic [REM_BITS-1:0] trial;
  logic                ge;

  // bring in the next two radicand bits and try root*4+1
  always_comb begin
    rem_sh = {rem_i[REM_BITS-3:0], rad_i[RAD_BITS-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[RAD_BITS-3:0], 2'b00};
      rem_o  <= ge ? rem_sh - trial : rem_sh;
      root_o <= {root_i[ROOT_BITS-2:0], ge};
      nrm_o  <= nrm_i;
    end
  end

endmodule

[rtl/hsw_div_cell.sv]
// hsw_div_cell: one restoring-division step, one quotient bit, registered.
// Depends on hsw_pkg.
module hsw_div_cell import hsw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctl_t                 ctl_i,
  input  logic [ROOT_BITS-1:0] den_i,
  input  logic [ROOT_BITS-1:0] rem_i,
  input  logic [QUO_BITS-1:0]  lo_i,
  input  logic [QUO_BITS-1:0]  quo_i,
  output ctl_t                 ctl_o,
  output logic [ROOT_BITS-1:0] den_o,
  output logic [ROOT_BITS-1:0] rem_o,
  output logic [QUO_BITS-1:0]  lo_o,
  output logic [QUO_BITS-1:0]  quo_o
);

  logic [ROOT_BITS:0] rem_sh;
  logic [ROOT_BITS:0] diff;
  logic               ge;

  // partial remainder stays below the divisor, so one compare decides the bit
  always_comb begin
    rem_sh = {rem_i, lo_i[QUO_BITS-1]};
    diff   = rem_sh - {1'b0, den_i};
    ge     = rem_sh >= {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_o <= den_i;
      rem_o <= ge ? diff[ROOT_BITS-1:0] : rem_sh[ROOT_BITS-1:0];
      lo_o  <= {lo_i[QUO_BITS-2:0], 1'b0};
      quo_o <= {quo_i[QUO_BITS-2:0], ge};
    end
  end

endmodule
